### rtl/zlib_stored_block_framer_unit_macros.svh
// Assertion macros shared by the checker of the stored-block framer.
`ifndef ZLIB_STORED_BLOCK_FRAMER_UNIT_MACROS_SVH
`define ZLIB_STORED_BLOCK_FRAMER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZSBF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("zsbf same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ZSBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("zsbf next-cycle check failed");

`endif

### rtl/zsbf_pkg.sv
// Package with the types and constants of the zlib stored-block framer.
`default_nettype none
package zsbf_pkg;
	localparam int unsigned BURST_LEN = 11;
	localparam int unsigned COUNT_W = 4;
	localparam int unsigned S_DATA_W = 48;

	localparam logic [16:0] ADLER_MOD = 17'd65521;
	localparam logic [16:0] FRAME_EXTRA = 17'd11;
	localparam logic [7:0] ZLIB_CMF = 8'h78;
	localparam logic [7:0] ZLIB_FLG = 8'h01;
	localparam logic [7:0] BLOCK_HDR = 8'h01;
	localparam logic [7:0] BYTE_MASK = 8'hff;

	localparam logic [COUNT_W-1:0] CNT_ERROR = 4'd1;
	localparam logic [COUNT_W-1:0] CNT_HEADER = 4'd7;
	localparam logic [COUNT_W-1:0] CNT_EMPTY_MSG = 4'd11;
	localparam logic [COUNT_W-1:0] CNT_DATA = 4'd1;
	localparam logic [COUNT_W-1:0] CNT_DATA_END = 4'd5;

	typedef enum logic {
		KIND_START = 1'b0,
		KIND_DATA = 1'b1
	} kind_t;

	typedef struct packed {
		logic [BURST_LEN-1:0][7:0] bytes;
		logic [COUNT_W-1:0] count;
		logic ends_stream;
		logic error;
	} burst_t;
endpackage
`default_nettype wire

### rtl/zsbf_framer.sv
// Framing state, Adler-32 update and output burst builder for one request.
`default_nettype none
module zsbf_framer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic load,
	input wire logic kind,
	input wire logic [15:0] message_length,
	input wire logic [16:0] room,
	input wire logic [7:0] data_byte,
	output zsbf_pkg::burst_t burst
);
	import zsbf_pkg::*;

	logic [15:0] sum_low_q;
	logic [15:0] sum_high_q;
	logic [15:0] bytes_left_q;
	logic in_message_q;
	logic discarding_q;

	logic [15:0] sum_low_d;
	logic [15:0] sum_high_d;
	logic [15:0] bytes_left_d;
	logic in_message_d;
	logic discarding_d;

	logic [16:0] low_sum;
	logic [15:0] low_next;
	logic [16:0] high_sum;
	logic [15:0] high_next;
	logic [16:0] need;
	logic [15:0] left_dec;

	always_comb begin
		low_sum = {1'b0, sum_low_q} + {9'd0, data_byte};
		low_next = (low_sum >= ADLER_MOD) ? 16'(low_sum - ADLER_MOD) : low_sum[15:0];
		high_sum = {1'b0, sum_high_q} + {1'b0, low_next};
		high_next = (high_sum >= ADLER_MOD) ? 16'(high_sum - ADLER_MOD) : high_sum[15:0];
		need = {1'b0, message_length} + FRAME_EXTRA;
		left_dec = bytes_left_q - 16'd1;

		sum_low_d = sum_low_q;
		sum_high_d = sum_high_q;
		bytes_left_d = bytes_left_q;
		in_message_d = in_message_q;
		discarding_d = discarding_q;
		burst = '0;

		case (kind_t'(kind))
			KIND_START: begin
				sum_low_d = 16'd1;
				sum_high_d = 16'd0;
				bytes_left_d = message_length;
				in_message_d = 1'b0;
				discarding_d = 1'b0;
				if (room < need) begin
					discarding_d = (message_length != 16'd0);
					burst.count = CNT_ERROR;
					burst.ends_stream = 1'b1;
					burst.error = 1'b1;
				end else begin
					burst.bytes[0] = ZLIB_CMF;
					burst.bytes[1] = ZLIB_FLG;
					burst.bytes[2] = BLOCK_HDR;
					burst.bytes[3] = message_length[7:0];
					burst.bytes[4] = message_length[15:8];
					burst.bytes[5] = message_length[7:0] ^ BYTE_MASK;
					burst.bytes[6] = message_length[15:8] ^ BYTE_MASK;
					if (message_length == 16'd0) begin
						burst.bytes[7] = 8'h00;
						burst.bytes[8] = 8'h00;
						burst.bytes[9] = 8'h00;
						burst.bytes[10] = 8'h01;
						burst.count = CNT_EMPTY_MSG;
						burst.ends_stream = 1'b1;
					end else begin
						burst.count = CNT_HEADER;
						in_message_d = 1'b1;
					end
				end
			end
			KIND_DATA: begin
				if (in_message_q) begin
					sum_low_d = low_next;
					sum_high_d = high_next;
					bytes_left_d = left_dec;
					burst.bytes[0] = data_byte;
					burst.count = CNT_DATA;
					if (left_dec == 16'd0) begin
						in_message_d = 1'b0;
						burst.bytes[1] = high_next[15:8];
						burst.bytes[2] = high_next[7:0];
						burst.bytes[3] = low_next[15:8];
						burst.bytes[4] = low_next[7:0];
						burst.count = CNT_DATA_END;
						burst.ends_stream = 1'b1;
					end
				end else if (discarding_q) begin
					bytes_left_d = left_dec;
					if (left_dec == 16'd0) begin
						discarding_d = 1'b0;
					end
				end
			end
			default: begin
				burst = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_low_q <= 16'd1;
			sum_high_q <= 16'd0;
			bytes_left_q <= 16'd0;
			in_message_q <= 1'b0;
			discarding_q <= 1'b0;
		end else if (load) begin
			sum_low_q <= sum_low_d;
			sum_high_q <= sum_high_d;
			bytes_left_q <= bytes_left_d;
			in_message_q <= in_message_d;
			discarding_q <= discarding_d;
		end
	end
endmodule
`default_nettype wire

### rtl/zlib_stored_block_framer_unit.sv
// Top level of the zlib stored-block framer with Adler-32 trailer.
//
//   channel   dir  tdata                                        tuser   tlast
//   s_axis    in   [15:0] len, [32:16] room, [40:33] byte       kind    -
//   m_axis    out  [7:0] out_byte                               error   last
//
// A request is held in the input register, then made into a burst of zero to eleven
// output bytes; it drains one byte per cycle unless stalled. Requests are taken
// every cycle while bursts hold at most one byte and the output is ready; else the
// input stalls only for the header and trailer bytes that the output port must
// serialize. An output stall holds the burst register and backs up into the input
// register. Reset clears all control state at once; no clearing pass is needed.
`default_nettype none
module zlib_stored_block_framer_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [zsbf_pkg::S_DATA_W-1:0] s_tdata, // message_length, room, data_byte
	input wire logic s_tuser, // kind
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [7:0] m_tdata, // out_byte
	output logic m_tuser, // error
	output logic m_tlast
);
	import zsbf_pkg::*;

	logic valid_s1;
	logic kind_s1;
	logic [15:0] length_s1;
	logic [16:0] room_s1;
	logic [7:0] byte_s1;

	logic [BURST_LEN-1:0][7:0] bytes_q;
	logic [COUNT_W-1:0] count_q;
	logic ends_q;
	logic error_q;

	logic burst_free;
	logic load;
	burst_t burst;

	assign m_tvalid = (count_q != '0);
	assign burst_free = (count_q == '0) || ((count_q == COUNT_W'(1)) && m_tready);
	assign load = valid_s1 && burst_free;
	assign s_tready = !valid_s1 || load;
	assign m_tdata = bytes_q[0];
	assign m_tuser = error_q;
	assign m_tlast = ends_q && (count_q == COUNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			length_s1 <= s_tdata[15:0];
			room_s1 <= s_tdata[32:16];
			byte_s1 <= s_tdata[40:33];
		end
	end

	zsbf_framer u_framer (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.kind(kind_s1),
		.message_length(length_s1),
		.room(room_s1),
		.data_byte(byte_s1),
		.burst(burst)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ends_q <= 1'b0;
			error_q <= 1'b0;
		end else if (load) begin
			count_q <= burst.count;
			ends_q <= burst.ends_stream;
			error_q <= burst.error;
		end else if (m_tvalid && m_tready) begin
			count_q <= count_q - COUNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= burst.bytes;
		end else if (m_tvalid && m_tready) begin
			bytes_q <= bytes_q >> 8;
		end
	end
endmodule
`default_nettype wire

### rtl/zsbf_checker.sv
// Port-level checker for the zlib stored-block framer, bound to the top level.
`default_nettype none
`include "zlib_stored_block_framer_unit_macros.svh"
module zsbf_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic [zsbf_pkg::S_DATA_W-1:0] s_tdata,
	input wire logic s_tuser,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic m_tuser,
	input wire logic m_tlast
);
	import zsbf_pkg::*;

	logic unused_ok;
	assign unused_ok = s_tvalid ^ (^s_tdata) ^ s_tuser;

	// A stalled output byte and its flags stay put.
	`ZSBF_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

	// A refused message yields a single zero byte that closes the stream.
	`ZSBF_ASSERT_SAME(a_error_form, clk, arst_n, m_tvalid && m_tuser, m_tlast && (m_tdata == 8'h00))

	// With no output pending, the input side is always open.
	`ZSBF_ASSERT_SAME(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready)

	// After an error result the next byte starts a fresh header or another error.
	`ZSBF_ASSERT_NEXT(a_after_error, clk, arst_n, m_tvalid && m_tready && m_tuser, !m_tvalid || m_tuser || (m_tdata == ZLIB_CMF))
endmodule

bind zlib_stored_block_framer_unit zsbf_checker u_zsbf_checker (.*);
`default_nettype wire
